@@ hdl/obst_pkg.sv @@
// shared widths, codes and types for the optimal search tree table builder
// no dependencies
package obst_pkg;

    localparam int KEY_W  = 4;
    localparam int WGT_W  = 13;
    localparam int COST_W = 20;
    localparam int DATA_W = 8;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic ROW_SUMMARY = 1'b0;
    localparam logic ROW_NODE    = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
    } span_t;

endpackage

@@ hdl/optimal_bst_table_builder_top.sv @@
// optimal binary search tree builder: items are loaded while idle; after the last item the
// table fill runs a diagonal pass, then per span two root table reads (single read port),
// the window bounds and one cost table read-add-compare step per candidate root.
// results follow: a summary row, then one node row per key, each built from root table reads.
// one problem at a time; rst_n clears control state asynchronously, key_count resets to 1.
// depends on obst_pkg and obst_ram
module optimal_bst_table_builder_top #(
    parameter int MAX_KEYS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [obst_pkg::KEY_W-1:0] key_count,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [obst_pkg::KEY_W-1:0] position,
    input  logic [obst_pkg::DATA_W-1:0] success_weight,
    input  logic [obst_pkg::DATA_W-1:0] failure_weight,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       row_kind,
    output logic [obst_pkg::KEY_W-1:0] node,
    output logic [obst_pkg::KEY_W-1:0] left_child,
    output logic [obst_pkg::KEY_W-1:0] right_child,
    output logic [obst_pkg::COST_W-1:0] total_cost,
    output logic                       last_row
);

    localparam int KW     = obst_pkg::KEY_W;
    localparam int CW     = obst_pkg::COST_W;
    localparam int WW     = obst_pkg::WGT_W;
    localparam int DIM    = MAX_KEYS + 1;
    localparam int DEPTH  = DIM * DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SI_W   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int QC_W   = $clog2(DIM + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIAG = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_WIN  = 4'd4;
    localparam logic [3:0] S_C1   = 4'd5;
    localparam logic [3:0] S_C2   = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_SUM0 = 4'd8;
    localparam logic [3:0] S_SUM1 = 4'd9;
    localparam logic [3:0] S_POP  = 4'd10;
    localparam logic [3:0] S_TK   = 4'd11;
    localparam logic [3:0] S_TL   = 4'd12;
    localparam logic [3:0] S_TR   = 4'd13;

    logic [3:0]          state_reg;
    logic [KW-1:0]       key_count_reg;
    logic [KW-1:0]       n_reg;
    logic [KW-1:0]       i_reg, j_reg, len_reg;
    logic [KW-1:0]       lo_reg, hi_reg, m_reg, lo_raw_reg;
    logic [WW-1:0]       wprev_reg, wsum_reg;
    logic [CW-1:0]       best_reg;
    logic [KW-1:0]       bestm_reg;
    logic [KW-1:0]       walk_i_reg, walk_j_reg, k_reg, left_reg;
    logic                kval_reg;
    logic [KW-1:0]       cnt_reg;
    logic [QC_W-1:0]     q_head_reg, q_tail_reg;
    obst_pkg::span_t     queue_reg [DIM];
    logic [obst_pkg::DATA_W-1:0] succ_reg [DIM];
    logic [obst_pkg::DATA_W-1:0] fail_reg [DIM];

    logic                out_valid_reg;
    logic                row_kind_reg, last_row_reg;
    logic [KW-1:0]       node_reg, left_out_reg, right_out_reg;
    logic [CW-1:0]       cost_out_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [WW-1:0]       w_wdata, w_rdata;
    logic [CW-1:0]       c_wdata, ca_rdata, cb_rdata;
    logic [KW-1:0]       r_wdata, r_rdata;
    logic [ADDR_W-1:0]   w_raddr, ca_raddr, cb_raddr, r_raddr;

    logic                out_free;
    logic                row_load;
    logic [CW:0]         pair_sum, tot_sum;
    logic [CW-1:0]       pair_sat, tot_sat;
    logic [KW:0]         lo_c, hi_c;
    logic [KW-1:0]       n_clamp;
    logic [KW-1:0]       right_val, left_val;
    obst_pkg::span_t     head_span;

    function automatic logic [ADDR_W-1:0] tab_addr(input logic [KW-1:0] r, input logic [KW-1:0] c);
        return ADDR_W'(int'(r) * DIM + int'(c));
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign row_load  = out_free && (state_reg == S_SUM1 || state_reg == S_TR);

    assign out_valid   = out_valid_reg;
    assign row_kind    = row_kind_reg;
    assign node        = node_reg;
    assign left_child  = left_out_reg;
    assign right_child = right_out_reg;
    assign total_cost  = cost_out_reg;
    assign last_row    = last_row_reg;

    assign head_span = queue_reg[q_head_reg[SI_W-1:0]];

    always_comb
    begin
        if (key_count_reg == '0)
            n_clamp = KW'(1);
        else if (int'(key_count_reg) > MAX_KEYS)
            n_clamp = KW'(MAX_KEYS);
        else
            n_clamp = key_count_reg;
    end

    // saturating adds for the root search and the final cost
    assign pair_sum = {1'b0, ca_rdata} + {1'b0, cb_rdata};
    assign pair_sat = pair_sum[CW] ? obst_pkg::COST_MAX : pair_sum[CW-1:0];
    assign tot_sum  = (CW + 1)'(wsum_reg) + {1'b0, best_reg};
    assign tot_sat  = tot_sum[CW] ? obst_pkg::COST_MAX : tot_sum[CW-1:0];

    // knuth window bounds, clamped to i+1..j
    always_comb
    begin
        lo_c = {1'b0, lo_raw_reg};
        hi_c = {1'b0, r_rdata};
        if (lo_c < {1'b0, i_reg} + 1'b1)
            lo_c = {1'b0, i_reg} + 1'b1;
        if (lo_c > {1'b0, j_reg})
            lo_c = {1'b0, j_reg};
        if (hi_c > {1'b0, j_reg})
            hi_c = {1'b0, j_reg};
        if (hi_c < lo_c)
            hi_c = lo_c;
    end

    assign left_val  = kval_reg ? left_reg : '0;
    assign right_val = kval_reg ? r_rdata : '0;

    // read addresses follow the state so that data stays put while waiting
    always_comb
    begin
        w_raddr  = tab_addr(i_reg, j_reg - 1'b1);
        ca_raddr = tab_addr(i_reg, m_reg - 1'b1);
        cb_raddr = tab_addr(m_reg, j_reg);
        r_raddr  = tab_addr(i_reg, j_reg - 1'b1);
        unique case (state_reg)
            S_RD2:          r_raddr = tab_addr(i_reg + 1'b1, j_reg);
            S_SUM0, S_SUM1:
            begin
                r_raddr  = tab_addr('0, n_reg);
                ca_raddr = tab_addr('0, n_reg);
            end
            S_POP:          r_raddr = tab_addr(head_span.lo, head_span.hi);
            S_TK:           r_raddr = tab_addr(walk_i_reg, r_rdata - 1'b1);
            S_TL, S_TR:     r_raddr = tab_addr(k_reg, walk_j_reg);
            default:        r_raddr = tab_addr(i_reg, j_reg - 1'b1);
        endcase
    end

    always_comb
    begin
        mem_we    = (state_reg == S_DIAG) || (state_reg == S_WR);
        mem_waddr = tab_addr(i_reg, (state_reg == S_DIAG) ? i_reg : j_reg);
        if (state_reg == S_DIAG)
        begin
            w_wdata = WW'(fail_reg[i_reg[SI_W-1:0]]);
            c_wdata = '0;
            r_wdata = '0;
        end
        else
        begin
            w_wdata = wsum_reg;
            c_wdata = tot_sat;
            r_wdata = bestm_reg;
        end
    end

    obst_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_weight (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    // cost table kept twice so both halves of a split are read in the same cycle
    obst_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cost_a (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(c_wdata),
        .raddr(ca_raddr), .rdata(ca_rdata)
    );

    obst_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cost_b (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(c_wdata),
        .raddr(cb_raddr), .rdata(cb_rdata)
    );

    obst_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_root (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    // weight stores and output payload carry no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && int'(position) <= MAX_KEYS)
        begin
            if (position != '0)
                succ_reg[position[SI_W-1:0]] <= success_weight;
            fail_reg[position[SI_W-1:0]] <= failure_weight;
        end
        if (state_reg == S_SUM1 && out_free)
        begin
            row_kind_reg  <= obst_pkg::ROW_SUMMARY;
            node_reg      <= r_rdata;
            left_out_reg  <= '0;
            right_out_reg <= '0;
            cost_out_reg  <= ca_rdata;
            last_row_reg  <= 1'b0;
        end
        else if (state_reg == S_TR && out_free)
        begin
            row_kind_reg  <= obst_pkg::ROW_NODE;
            node_reg      <= k_reg;
            left_out_reg  <= left_val;
            right_out_reg <= right_val;
            cost_out_reg  <= '0;
            last_row_reg  <= (cnt_reg + 1'b1 == n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_count_reg <= KW'(1);
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            q_head_reg    <= '0;
            q_tail_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                key_count_reg <= key_count;
            if (row_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && last_item)
                    begin
                        n_reg     <= n_clamp;
                        i_reg     <= '0;
                        state_reg <= S_DIAG;
                    end
                end
                S_DIAG:
                begin
                    if (i_reg == n_reg)
                    begin
                        i_reg     <= '0;
                        j_reg     <= KW'(1);
                        len_reg   <= KW'(1);
                        state_reg <= S_RD1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_RD1:
                begin
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    lo_raw_reg <= r_rdata;
                    wprev_reg  <= w_rdata;
                    state_reg  <= S_WIN;
                end
                S_WIN:
                begin
                    lo_reg    <= lo_c[KW-1:0];
                    hi_reg    <= hi_c[KW-1:0];
                    m_reg     <= lo_c[KW-1:0];
                    wsum_reg  <= wprev_reg + WW'(succ_reg[j_reg[SI_W-1:0]])
                                 + WW'(fail_reg[j_reg[SI_W-1:0]]);
                    state_reg <= S_C1;
                end
                S_C1:
                begin
                    state_reg <= S_C2;
                end
                S_C2:
                begin
                    // first minimum wins on ties
                    if (m_reg == lo_reg || pair_sat < best_reg)
                    begin
                        best_reg  <= pair_sat;
                        bestm_reg <= m_reg;
                    end
                    if (m_reg == hi_reg)
                    begin
                        state_reg <= S_WR;
                    end
                    else
                    begin
                        m_reg     <= m_reg + 1'b1;
                        state_reg <= S_C1;
                    end
                end
                S_WR:
                begin
                    if (j_reg == n_reg)
                    begin
                        if (len_reg == n_reg)
                        begin
                            state_reg <= S_SUM0;
                        end
                        else
                        begin
                            len_reg   <= len_reg + 1'b1;
                            i_reg     <= '0;
                            j_reg     <= len_reg + 1'b1;
                            state_reg <= S_RD1;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RD1;
                    end
                end
                S_SUM0:
                begin
                    state_reg <= S_SUM1;
                end
                S_SUM1:
                begin
                    if (out_free)
                    begin
                        queue_reg[0]  <= '{lo: '0, hi: n_reg};
                        q_head_reg    <= '0;
                        q_tail_reg    <= QC_W'(1);
                        cnt_reg       <= '0;
                        state_reg     <= S_POP;
                    end
                end
                S_POP:
                begin
                    walk_i_reg <= head_span.lo;
                    walk_j_reg <= head_span.hi;
                    q_head_reg <= q_head_reg + 1'b1;
                    state_reg  <= S_TK;
                end
                S_TK:
                begin
                    k_reg     <= r_rdata;
                    kval_reg  <= ({1'b0, r_rdata} >= {1'b0, walk_i_reg} + 1'b1)
                                 && (r_rdata <= walk_j_reg);
                    state_reg <= S_TL;
                end
                S_TL:
                begin
                    left_reg  <= r_rdata;
                    state_reg <= S_TR;
                end
                S_TR:
                begin
                    if (out_free)
                    begin
                        if (left_val != '0 && right_val != '0 && int'(q_tail_reg) < MAX_KEYS)
                        begin
                            queue_reg[q_tail_reg[SI_W-1:0]] <=
                                '{lo: walk_i_reg, hi: k_reg - 1'b1};
                            queue_reg[SI_W'(q_tail_reg + 1'b1)] <=
                                '{lo: k_reg, hi: walk_j_reg};
                            q_tail_reg <= q_tail_reg + QC_W'(2);
                        end
                        else if (left_val != '0 && int'(q_tail_reg) <= MAX_KEYS)
                        begin
                            queue_reg[q_tail_reg[SI_W-1:0]] <=
                                '{lo: walk_i_reg, hi: k_reg - 1'b1};
                            q_tail_reg <= q_tail_reg + 1'b1;
                        end
                        else if (right_val != '0 && int'(q_tail_reg) <= MAX_KEYS)
                        begin
                            queue_reg[q_tail_reg[SI_W-1:0]] <= '{lo: k_reg, hi: walk_j_reg};
                            q_tail_reg <= q_tail_reg + 1'b1;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg + 1'b1 == n_reg)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_POP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // root candidate stays inside the clamped window
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_C2 |-> (m_reg >= lo_reg && m_reg <= hi_reg))
        else $error("root candidate outside search window");

    // the span queue never reads past what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> q_head_reg < q_tail_reg)
        else $error("span queue underflow");

    // a node row always names a real key
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && row_kind_reg == obst_pkg::ROW_NODE) |-> node_reg != '0)
        else $error("node row with empty key");

    // no new row is loaded over one that is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && (state_reg == S_TR || state_reg == S_SUM1))
        |=> $stable(node_reg))
        else $error("pending row overwritten");

endmodule

@@ hdl/obst_ram.sv @@
// generic single write, single read memory with registered read data
// no dependencies
module obst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
